// ===== design/calo_hit_layers_from_edge_defines.svh =====
// Assertion macros used by calo_hit_layers_from_edge.sv.
`ifndef CALO_HIT_LAYERS_FROM_EDGE_DEFINES_SVH
`define CALO_HIT_LAYERS_FROM_EDGE_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset
`define CHLFE_ASSERT_SAME(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define CHLFE_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/chlfe_pkg.sv =====
package chlfe_pkg;

   // field widths
   localparam int POS_W      = 20;
   localparam int COORD_W    = 19;
   localparam int INV_W      = 16;
   localparam int LAYER_W    = 8;
   localparam int CNT_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   // datapath widths
   localparam int CORDIC_STEPS = 16;
   localparam int PRE_SHIFT    = 8;
   localparam int LANE_W       = 31;
   localparam int PROJ_W       = 30;
   localparam int DIFF_W       = 32;
   localparam int DIST_W       = 48;
   localparam int FRAC_BITS    = 28;
   localparam int QUOT_W       = DIST_W - FRAC_BITS;
   localparam int GAIN_SHIFT   = 30;
   localparam logic signed [LANE_W-1:0] GAIN_Q30 = 31'sd652032874;

   // count range
   localparam int CNT_MAX = (1 << (CNT_W - 1)) - 1;

   // polygon defaults
   localparam int DEF_BARREL_SIDES = 16;
   localparam int DEF_ENDCAP_SIDES = 8;
   localparam int DEF_BARREL_PHI0  = 0;
   localparam int DEF_ENDCAP_PHI0  = 0;

   // register reset values
   localparam logic [COORD_W-1:0] RST_BARREL_END_Z        = 19'd35000;
   localparam logic [COORD_W-1:0] RST_BARREL_OUTER_RADIUS = 19'd53000;
   localparam logic [COORD_W-1:0] RST_ENDCAP_OUTER_RADIUS = 19'd53000;
   localparam logic [COORD_W-1:0] RST_ENDCAP_OUTER_Z      = 19'd63000;
   localparam logic [INV_W-1:0]   RST_BARREL_INV_THICK    = 16'd2520;
   localparam logic [INV_W-1:0]   RST_ENDCAP_INV_THICK    = 16'd2520;
   localparam logic [LAYER_W-1:0] RST_MAX_REAR_LAYERS     = 8'd4;
   localparam logic [LAYER_W-1:0] RST_OUTER_SAMPLING      = 8'd3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BARREL_END_Z        = 3'd0,
      CSR_BARREL_OUTER_RADIUS = 3'd1,
      CSR_ENDCAP_OUTER_RADIUS = 3'd2,
      CSR_ENDCAP_OUTER_Z      = 3'd3,
      CSR_BARREL_INV_THICK    = 3'd4,
      CSR_ENDCAP_INV_THICK    = 3'd5,
      CSR_MAX_REAR_LAYERS     = 3'd6,
      CSR_OUTER_SAMPLING      = 3'd7
   } csr_index_type;

   // arctangent table, 2^32 per turn
   localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21366753,
      10680862, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861
   };

   // Rotation directions for a fixed residual angle; bit k set means
   // the angle accumulator was not negative at step k.
   function automatic logic [CORDIC_STEPS-1:0] cordic_dirs(input logic [29:0] resid);
      longint                  acc;
      logic [CORDIC_STEPS-1:0] dirs;
      acc  = longint'(resid);
      dirs = '0;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (acc >= 0) begin
            dirs[k] = 1'b1;
            acc     = acc - ATAN_TURNS[k];
         end else begin
            acc     = acc + ATAN_TURNS[k];
         end
      end
      return dirs;
   endfunction

endpackage

// ===== design/calo_hit_layers_from_edge.sv =====
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | req_pos_x, req_pos_y, req_pos_z
// rsp     | out       | rsp_valid/stall    | rsp_layers_from_edge, rsp_in_outer_sampling
// csr     | in        | csr_wen            | csr_index, csr_wdata
//
// One hit per cycle sustained while rsp_stall stays low. Stages: 1 input
// stage, 16 rotation stages, 1 gain multiply, one stage per level of the face
// maximum tree, then difference, multiply, select and count stages.
// Synchronous active-high reset clears all valid bits and loads register defaults.
// Each stage holds its item while the next one is full; empty stages fill
// under a stall, so req_stall rises only once every stage is occupied.
`include "calo_hit_layers_from_edge_defines.svh"

module calo_hit_layers_from_edge
   import chlfe_pkg::*;
#(
   parameter int BARREL_SIDES = DEF_BARREL_SIDES,
   parameter int ENDCAP_SIDES = DEF_ENDCAP_SIDES,
   parameter int BARREL_PHI0  = DEF_BARREL_PHI0,
   parameter int ENDCAP_PHI0  = DEF_ENDCAP_PHI0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [POS_W-1:0]    req_pos_x,
   input  logic signed [POS_W-1:0]    req_pos_y,
   input  logic signed [POS_W-1:0]    req_pos_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [CNT_W-1:0]    rsp_layers_from_edge,
   output logic                       rsp_in_outer_sampling,
   input  logic                       csr_wen,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // stage map
   localparam int MAX_SIDES = (BARREL_SIDES > ENDCAP_SIDES) ? BARREL_SIDES : ENDCAP_SIDES;
   localparam int TREE_LVLS = $clog2(MAX_SIDES);
   localparam int NP        = 1 << TREE_LVLS;
   localparam int ST_GAIN   = CORDIC_STEPS + 1;
   localparam int ST_DIFF   = ST_GAIN + TREE_LVLS + 1;
   localparam int ST_MUL    = ST_DIFF + 1;
   localparam int ST_SEL    = ST_MUL + 1;
   localparam int ST_OUT    = ST_SEL + 1;
   localparam int N_ST      = ST_OUT + 1;

   // configuration registers
   logic [COORD_W-1:0] barrel_end_z_ff, barrel_outer_radius_ff;
   logic [COORD_W-1:0] endcap_outer_radius_ff, endcap_outer_z_ff;
   logic [INV_W-1:0]   barrel_inv_ff, endcap_inv_ff;
   logic [LAYER_W-1:0] max_rear_ff, outer_sampling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         barrel_end_z_ff        <= RST_BARREL_END_Z;
         barrel_outer_radius_ff <= RST_BARREL_OUTER_RADIUS;
         endcap_outer_radius_ff <= RST_ENDCAP_OUTER_RADIUS;
         endcap_outer_z_ff      <= RST_ENDCAP_OUTER_Z;
         barrel_inv_ff          <= RST_BARREL_INV_THICK;
         endcap_inv_ff          <= RST_ENDCAP_INV_THICK;
         max_rear_ff            <= RST_MAX_REAR_LAYERS;
         outer_sampling_ff      <= RST_OUTER_SAMPLING;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_BARREL_END_Z:        barrel_end_z_ff        <= csr_wdata[COORD_W-1:0];
            CSR_BARREL_OUTER_RADIUS: barrel_outer_radius_ff <= csr_wdata[COORD_W-1:0];
            CSR_ENDCAP_OUTER_RADIUS: endcap_outer_radius_ff <= csr_wdata[COORD_W-1:0];
            CSR_ENDCAP_OUTER_Z:      endcap_outer_z_ff      <= csr_wdata[COORD_W-1:0];
            CSR_BARREL_INV_THICK:    barrel_inv_ff          <= csr_wdata[INV_W-1:0];
            CSR_ENDCAP_INV_THICK:    endcap_inv_ff          <= csr_wdata[INV_W-1:0];
            CSR_MAX_REAR_LAYERS:     max_rear_ff            <= csr_wdata[LAYER_W-1:0];
            CSR_OUTER_SAMPLING:      outer_sampling_ff      <= csr_wdata[LAYER_W-1:0];
         endcase
      end
   end

   // valid chain; a stage loads when empty or when its successor loads
   logic [N_ST-1:0] vld_ff;
   logic [N_ST:0]   ready;

   assign ready[N_ST] = !rsp_stall;
   for (genvar s = 0; s < N_ST; s++) begin : g_ctl
      assign ready[s] = !vld_ff[s] || ready[s+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            vld_ff[s] <= (s == 0) ? req_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = vld_ff[N_ST-1];

   // |z| travels alongside the projections
   logic [POS_W-1:0] absz_in;
   logic [POS_W-1:0] absz_ff [ST_DIFF];

   assign absz_in = req_pos_z[POS_W-1] ? POS_W'(-req_pos_z) : POS_W'(req_pos_z);

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         absz_ff[0] <= absz_in;
      end
   end

   for (genvar s = 1; s < ST_DIFF; s++) begin : g_absz
      always_ff @(posedge clock) begin
         if (ready[s]) begin
            absz_ff[s] <= absz_ff[s-1];
         end
      end
   end

   // face lanes
   logic signed [LANE_W-1:0] bproj [BARREL_SIDES];
   logic signed [LANE_W-1:0] eproj [ENDCAP_SIDES];

   for (genvar i = 0; i < BARREL_SIDES; i++) begin : g_blane
      chlfe_cordic_lane #(
         .FACE  (i),
         .SIDES (BARREL_SIDES),
         .PHI0  (BARREL_PHI0)
      ) u_lane (
         .clock    (clock),
         .stage_en (ready[ST_GAIN:0]),
         .pos_x    (req_pos_x),
         .pos_y    (req_pos_y),
         .proj     (bproj[i])
      );
   end

   for (genvar i = 0; i < ENDCAP_SIDES; i++) begin : g_elane
      chlfe_cordic_lane #(
         .FACE  (i),
         .SIDES (ENDCAP_SIDES),
         .PHI0  (ENDCAP_PHI0)
      ) u_lane (
         .clock    (clock),
         .stage_en (ready[ST_GAIN:0]),
         .pos_x    (req_pos_x),
         .pos_y    (req_pos_y),
         .proj     (eproj[i])
      );
   end

   // leaves, clamped at zero; padding leaves are zero
   logic [PROJ_W-1:0] bleaf [NP];
   logic [PROJ_W-1:0] eleaf [NP];

   for (genvar i = 0; i < NP; i++) begin : g_leaf
      if (i < BARREL_SIDES) begin : g_b
         assign bleaf[i] = bproj[i][LANE_W-1] ? '0 : PROJ_W'(bproj[i]);
      end else begin : g_bz
         assign bleaf[i] = '0;
      end
      if (i < ENDCAP_SIDES) begin : g_e
         assign eleaf[i] = eproj[i][LANE_W-1] ? '0 : PROJ_W'(eproj[i]);
      end else begin : g_ez
         assign eleaf[i] = '0;
      end
   end

   // maximum tree, heap order, one level per stage, root at index 1
   logic [PROJ_W-1:0] btree_ff [1:NP-1];
   logic [PROJ_W-1:0] etree_ff [1:NP-1];

   for (genvar j = 1; j < NP; j++) begin : g_node
      localparam int DEPTH = $clog2(j + 1) - 1;
      localparam int STAGE = ST_GAIN + TREE_LVLS - DEPTH;
      logic [PROJ_W-1:0] ba, bb, ea, eb;

      if (2 * j >= NP) begin : g_from_leaf
         assign ba = bleaf[2*j-NP];
         assign bb = bleaf[2*j+1-NP];
         assign ea = eleaf[2*j-NP];
         assign eb = eleaf[2*j+1-NP];
      end else begin : g_from_node
         assign ba = btree_ff[2*j];
         assign bb = btree_ff[2*j+1];
         assign ea = etree_ff[2*j];
         assign eb = etree_ff[2*j+1];
      end

      always_ff @(posedge clock) begin
         if (ready[STAGE]) begin
            btree_ff[j] <= (ba > bb) ? ba : bb;
            etree_ff[j] <= (ea > eb) ? ea : eb;
         end
      end
   end

   // differences to the edges
   logic signed [DIFF_W-1:0] bdiff_in, ediff_in, brear_in, erear_in;
   logic signed [DIFF_W-1:0] bdiff_ff, ediff_ff, brear_ff, erear_ff;
   logic                     inbar_in, inbar_diff_ff, inbar_mul_ff;
   logic [POS_W-1:0]         absz_d;

   assign absz_d   = absz_ff[ST_DIFF-1];
   assign bdiff_in = $signed(DIFF_W'({barrel_outer_radius_ff, {PRE_SHIFT{1'b0}}}))
                   - $signed(DIFF_W'(btree_ff[1]));
   assign ediff_in = $signed(DIFF_W'({endcap_outer_radius_ff, {PRE_SHIFT{1'b0}}}))
                   - $signed(DIFF_W'(etree_ff[1]));
   assign brear_in = $signed(DIFF_W'({barrel_end_z_ff, {PRE_SHIFT{1'b0}}}))
                   - $signed(DIFF_W'({absz_d, {PRE_SHIFT{1'b0}}}));
   assign erear_in = $signed(DIFF_W'({endcap_outer_z_ff, {PRE_SHIFT{1'b0}}}))
                   - $signed(DIFF_W'({absz_d, {PRE_SHIFT{1'b0}}}));
   assign inbar_in = absz_d < {1'b0, barrel_end_z_ff};

   always_ff @(posedge clock) begin
      if (ready[ST_DIFF]) begin
         bdiff_ff      <= bdiff_in;
         ediff_ff      <= ediff_in;
         brear_ff      <= brear_in;
         erear_ff      <= erear_in;
         inbar_diff_ff <= inbar_in;
      end
   end

   // distances in layers, Q28
   logic signed [DIST_W-1:0] brad_ff, erad_ff, brear_dist_ff, erear_dist_ff;

   always_ff @(posedge clock) begin
      if (ready[ST_MUL]) begin
         brad_ff       <= bdiff_ff * $signed({1'b0, barrel_inv_ff});
         erad_ff       <= ediff_ff * $signed({1'b0, endcap_inv_ff});
         brear_dist_ff <= brear_ff * $signed({1'b0, barrel_inv_ff});
         erear_dist_ff <= erear_ff * $signed({1'b0, endcap_inv_ff});
         inbar_mul_ff  <= inbar_diff_ff;
      end
   end

   // region and overlap selection
   logic signed [DIST_W-1:0] dist_in, dist_ff, rear_edge;
   logic                     rear_near;

   assign rear_near = brear_dist_ff < $signed(DIST_W'({max_rear_ff, {FRAC_BITS{1'b0}}}));
   assign rear_edge = (brear_dist_ff > erad_ff) ? brear_dist_ff : erad_ff;

   always_comb begin
      if (inbar_mul_ff) begin
         if (rear_near && (rear_edge < brad_ff)) begin
            dist_in = rear_edge;
         end else begin
            dist_in = brad_ff;
         end
      end else begin
         dist_in = (erear_dist_ff < erad_ff) ? erear_dist_ff : erad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[ST_SEL]) begin
         dist_ff <= dist_in;
      end
   end

   // truncate toward zero, saturate, flag
   logic [DIST_W-1:0]        dist_mag;
   logic [QUOT_W-1:0]        quot;
   logic signed [CNT_W-1:0]  cnt_in, cnt_ff;
   logic                     flag_in, flag_ff;

   assign dist_mag = dist_ff[DIST_W-1] ? DIST_W'(-dist_ff) : DIST_W'(dist_ff);
   assign quot     = dist_mag[DIST_W-1:FRAC_BITS];

   always_comb begin
      if (!dist_ff[DIST_W-1]) begin
         cnt_in = (quot > QUOT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(quot);
      end else begin
         cnt_in = (quot > QUOT_W'(CNT_MAX + 1)) ? CNT_W'(CNT_MAX + 1) : -CNT_W'(quot);
      end
   end

   assign flag_in = $signed({cnt_in[CNT_W-1], cnt_in}) <= $signed({2'b00, outer_sampling_ff});

   always_ff @(posedge clock) begin
      if (ready[ST_OUT]) begin
         cnt_ff  <= cnt_in;
         flag_ff <= flag_in;
      end
   end

   assign rsp_layers_from_edge  = cnt_ff;
   assign rsp_in_outer_sampling = flag_ff;

   // checks
   `CHLFE_ASSERT_SAME(a_stall_only_when_full, req_stall, vld_ff[0],
      "input stalled with an empty first stage")
   `CHLFE_ASSERT_SAME(a_flag_matches_count, rsp_valid,
      rsp_in_outer_sampling == ($signed({rsp_layers_from_edge[CNT_W-1], rsp_layers_from_edge})
                                <= $signed({2'b00, outer_sampling_ff})),
      "outer sampling flag disagrees with the count")
   `CHLFE_ASSERT_NEXT(a_sign_follows_dist, vld_ff[ST_SEL] && ready[ST_OUT] && !dist_ff[DIST_W-1],
      !rsp_layers_from_edge[CNT_W-1], "non-negative distance gave a negative count")
   `CHLFE_ASSERT_NEXT(a_no_invented_result, rsp_valid && !rsp_stall && !vld_ff[ST_SEL],
      !rsp_valid, "result appeared without an item behind it")

endmodule

// ===== design/chlfe_cordic_lane.sv =====
// One polygon face: quadrant fold, 16 shift-add rotation stages and the
// gain multiply, one register stage each.
module chlfe_cordic_lane
   import chlfe_pkg::*;
#(
   parameter int FACE  = 0,
   parameter int SIDES = DEF_BARREL_SIDES,
   parameter int PHI0  = DEF_BARREL_PHI0
) (
   input  logic                       clock,
   input  logic [CORDIC_STEPS+1:0]    stage_en,
   input  logic signed [POS_W-1:0]    pos_x,
   input  logic signed [POS_W-1:0]    pos_y,
   output logic signed [LANE_W-1:0]   proj
);

   // face angle in turns, 2^32 per turn
   localparam longint unsigned SIDES_EFF = (SIDES < 1) ? 64'd1 : longint'(SIDES);
   localparam longint unsigned PHI0_U    = longint'(PHI0);
   localparam longint unsigned FACE_U    = longint'(FACE);
   localparam logic [31:0] ANGLE =
      32'(((PHI0_U & 64'hFFFF) << 16) + ((FACE_U << 32) / SIDES_EFF));
   localparam logic [1:0]              QUADRANT = ANGLE[31:30];
   localparam logic [CORDIC_STEPS-1:0] DIRS     = cordic_dirs(ANGLE[29:0]);

   logic signed [LANE_W-1:0] sx, sy, rx, ry;
   logic signed [LANE_W-1:0] cx_ff [CORDIC_STEPS+1];
   logic signed [LANE_W-1:0] cy_ff [CORDIC_STEPS+1];
   logic signed [LANE_W-1:0] cx_in [CORDIC_STEPS];
   logic signed [LANE_W-1:0] cy_in [CORDIC_STEPS];
   logic signed [2*LANE_W-1:0] gain_prod;
   logic signed [LANE_W-1:0] proj_in, proj_ff;

   // scale by 256
   assign sx = {{(LANE_W-POS_W-PRE_SHIFT){pos_x[POS_W-1]}}, pos_x, {PRE_SHIFT{1'b0}}};
   assign sy = {{(LANE_W-POS_W-PRE_SHIFT){pos_y[POS_W-1]}}, pos_y, {PRE_SHIFT{1'b0}}};

   // -90 degree turn per whole quarter of the face angle
   always_comb begin
      case (QUADRANT)
         2'd0: begin
            rx = sx;
            ry = sy;
         end
         2'd1: begin
            rx = sy;
            ry = -sx;
         end
         2'd2: begin
            rx = -sx;
            ry = -sy;
         end
         default: begin
            rx = -sy;
            ry = sx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cx_ff[0] <= rx;
         cy_ff[0] <= ry;
      end
   end

   // rotation stages, directions fixed by the face angle
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [LANE_W-1:0] dx, dy;
      assign dx = cy_ff[k] >>> k;
      assign dy = cx_ff[k] >>> k;

      always_comb begin
         if (DIRS[k]) begin
            cx_in[k] = cx_ff[k] + dx;
            cy_in[k] = cy_ff[k] - dy;
         end else begin
            cx_in[k] = cx_ff[k] - dx;
            cy_in[k] = cy_ff[k] + dy;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k+1]) begin
            cx_ff[k+1] <= cx_in[k];
            cy_ff[k+1] <= cy_in[k];
         end
      end
   end

   // gain correction, floored
   assign gain_prod = cx_ff[CORDIC_STEPS] * GAIN_Q30;
   assign proj_in   = LANE_W'(gain_prod >>> GAIN_SHIFT);

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_STEPS+1]) begin
         proj_ff <= proj_in;
      end
   end

   assign proj = proj_ff;

endmodule
